[hw/rtl/lpl_pkg.sv]
// Shared types, codes and constants of the length-prefixed log ring.
package lpl_pkg;

  localparam int CAPACITY_DEF = 4096;
  localparam int LINE_MAX_DEF = 256;
  localparam int HDR = 2;
  localparam int MAX_W = 17;
  localparam int LC_W = 11;
  localparam int BU_W = 13;
  localparam int DC_W = 32;

  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_DOT = 8'h2E;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_OPEN  = 2'd1,
    CMD_NEXT  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_STAGED  = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_TOO_BIG = 3'd3,
    ST_NO_READ = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_EVC_CHK, S_EVC_H0, S_EVC_H1, S_WR_H0, S_WR_H1, S_CP_RD, S_CP_WR,
    S_DOT, S_CMT, S_OPN_CHK, S_OPN_H0, S_OPN_H1, S_RN_HA, S_RN_H0, S_RN_H1,
    S_RN_SEL, S_RN_B, S_DONE
  } state_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [7:0]       data_byte;
    logic             line_end;
    logic [MAX_W-1:0] rd_budget;
  } item_t;

endpackage

[hw/rtl/lpl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/lpl_front.sv]
// Front end: accepts transactions, decodes the command and queues them.
module lpl_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_cmd,
  input  logic [7:0]                in_data_byte,
  input  logic                      in_line_end,
  input  logic [lpl_pkg::MAX_W-1:0] in_rd_budget,
  output lpl_pkg::item_t            q_item,
  output logic                      q_vld,
  input  logic                      q_pop
);
  import lpl_pkg::*;

  item_t      ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push_w;
  item_t      dec_w;

  assign in_stall = (cnt_r == 2'd2);
  assign push_w = in_valid && !in_stall;
  assign q_vld = (cnt_r != 2'd0);
  assign q_item = ent_r[rp_r];

  always_comb begin
    dec_w.cmd = cmd_t'(in_cmd);
    dec_w.data_byte = in_data_byte;
    dec_w.line_end = in_line_end && (cmd_t'(in_cmd) == CMD_PUSH);
    dec_w.rd_budget = (cmd_t'(in_cmd) == CMD_OPEN) ? in_rd_budget : '0;
  end

  always_ff @(posedge clk) begin
    if (push_w) begin
      ent_r[wp_r] <= dec_w;
    end
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_w) begin
        wp_r <= ~wp_r;
      end
      if (q_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push_w} - {1'b0, q_pop};
    end
  end
endmodule

[hw/rtl/lpl_back.sv]
// Back end: executes commands against the ring and staging memories.
module lpl_back #(
  parameter int CAPACITY = lpl_pkg::CAPACITY_DEF,
  parameter int LINE_MAX = lpl_pkg::LINE_MAX_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lpl_pkg::item_t           q_item,
  input  logic                     q_vld,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [7:0]               out_out_byte,
  output logic                     out_out_valid,
  output logic                     out_out_last,
  output logic [2:0]               out_status,
  output logic [lpl_pkg::LC_W-1:0] out_line_count,
  output logic [lpl_pkg::BU_W-1:0] out_bytes_used,
  output logic [lpl_pkg::DC_W-1:0] out_dropped_count
);
  import lpl_pkg::*;

  localparam int POS_W = $clog2(CAPACITY);
  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam int LN_W = $clog2(CAPACITY / 2 + 1);
  localparam int REM_W = OCC_W + 1;
  localparam int SC_W = $clog2(LINE_MAX + 3);
  localparam int SA_W = $clog2(LINE_MAX);
  localparam int LL_W = $clog2(LINE_MAX + 2);

  function automatic logic [POS_W-1:0] wadd(input logic [POS_W-1:0] a, input logic [17:0] b);
    logic [18:0] s;
    s = 19'(a) + 19'(b);
    if (s >= 19'(CAPACITY)) begin
      s = s - 19'(CAPACITY);
    end
    return s[POS_W-1:0];
  endfunction

  state_t state_r, state_nxt;
  logic [POS_W-1:0] wpos_r, oldest_r, rpos_r, p_r;
  logic [OCC_W-1:0] occ_r;
  logic [LN_W-1:0]  lines_r, rlines_r, wi_r;
  logic [DC_W-1:0]  evict_r;
  logic [SC_W-1:0]  staged_r, kept_r, len_r, cp_r, need_r;
  logic             cut_r, ropen_r;
  logic [LL_W-1:0]  rline_r;
  logic [REM_W-1:0] rem_r;
  logic [MAX_W-1:0] max_r;
  logic [1:0]       dot_r;
  logic [7:0]       lo_r, res_byte_r;
  logic             res_vld_r, res_last_r;
  status_t          res_st_r;
  logic             o_vld_r;

  logic [7:0]       ring_rd, stg_rd, ring_wd;
  logic [POS_W-1:0] ring_ra;
  logic             ring_we, stg_we, out_free;
  logic [15:0]      hdr_w, tot_w;
  logic [SC_W-1:0]  kept_new, len_new, need_new, sp1;
  logic             cut_new, too_big, nc_w, evc_need, opn_go, walk_need;

  assign hdr_w = {ring_rd, lo_r};
  assign tot_w = 16'(need_r) - 16'(HDR);
  assign out_free = !o_vld_r || !out_stall;
  assign q_pop = (state_r == S_IDLE) && q_vld;
  assign out_valid = o_vld_r;

  assign nc_w = (q_item.data_byte != CH_NL) && (q_item.data_byte != CH_CR);
  assign sp1 = staged_r + SC_W'(1);
  assign kept_new = nc_w ? ((sp1 > SC_W'(LINE_MAX + 1)) ? SC_W'(LINE_MAX + 1) : sp1) : kept_r;
  assign cut_new = kept_new > SC_W'(LINE_MAX);
  assign len_new = cut_new ? SC_W'(LINE_MAX - 3) : kept_new;
  assign need_new = (cut_new ? SC_W'(LINE_MAX) : kept_new) + SC_W'(HDR);
  assign too_big = 32'(need_new) > 32'(CAPACITY);
  assign evc_need = (32'(occ_r) + 32'(need_r) > 32'(CAPACITY)) && (lines_r != '0);
  assign opn_go = (wi_r != lines_r) && (32'(rem_r) > 32'(max_r));
  assign walk_need = (q_item.rd_budget != '0) &&
                     (32'(occ_r) + 32'(lines_r) > 32'(q_item.rd_budget));

  lpl_ram #(.WIDTH(8), .DEPTH(CAPACITY)) u_ring (
    .clk(clk), .we(ring_we), .waddr(wpos_r), .wdata(ring_wd),
    .raddr(ring_ra), .rdata(ring_rd)
  );

  assign stg_we = q_pop && (q_item.cmd == CMD_PUSH) && (staged_r < SC_W'(LINE_MAX));

  lpl_ram #(.WIDTH(8), .DEPTH(LINE_MAX)) u_stage (
    .clk(clk), .we(stg_we), .waddr(staged_r[SA_W-1:0]), .wdata(q_item.data_byte),
    .raddr(cp_r[SA_W-1:0]), .rdata(stg_rd)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (q_vld) begin
          case (q_item.cmd)
            CMD_PUSH: begin
              if (q_item.line_end && kept_new != '0 && !too_big) begin
                state_nxt = S_EVC_CHK;
              end else begin
                state_nxt = S_DONE;
              end
            end
            CMD_OPEN: state_nxt = (lines_r != '0 && walk_need) ? S_OPN_CHK : S_DONE;
            CMD_NEXT: begin
              if (!ropen_r) begin
                state_nxt = S_DONE;
              end else if (rline_r == '0) begin
                state_nxt = S_RN_HA;
              end else begin
                state_nxt = S_RN_SEL;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_EVC_CHK: state_nxt = evc_need ? S_EVC_H0 : S_WR_H0;
      S_EVC_H0: state_nxt = S_EVC_H1;
      S_EVC_H1: state_nxt = S_EVC_CHK;
      S_WR_H0: state_nxt = S_WR_H1;
      S_WR_H1: state_nxt = S_CP_RD;
      S_CP_RD: state_nxt = S_CP_WR;
      S_CP_WR: begin
        if (cp_r + SC_W'(1) < len_r) begin
          state_nxt = S_CP_RD;
        end else begin
          state_nxt = cut_r ? S_DOT : S_CMT;
        end
      end
      S_DOT: state_nxt = (dot_r == 2'd2) ? S_CMT : S_DOT;
      S_CMT: state_nxt = S_DONE;
      S_OPN_CHK: state_nxt = opn_go ? S_OPN_H0 : S_DONE;
      S_OPN_H0: state_nxt = S_OPN_H1;
      S_OPN_H1: state_nxt = S_OPN_CHK;
      S_RN_HA: state_nxt = S_RN_H0;
      S_RN_H0: state_nxt = S_RN_H1;
      S_RN_H1: state_nxt = S_RN_SEL;
      S_RN_SEL: state_nxt = (rline_r > LL_W'(1)) ? S_RN_B : S_DONE;
      S_RN_B: state_nxt = S_DONE;
      S_DONE: state_nxt = out_free ? S_IDLE : S_DONE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ring_ra = oldest_r;
    ring_we = 1'b0;
    ring_wd = CH_DOT;
    case (state_r)
      S_EVC_H0: ring_ra = wadd(oldest_r, 18'd1);
      S_OPN_CHK: ring_ra = p_r;
      S_OPN_H0: ring_ra = wadd(p_r, 18'd1);
      S_RN_HA, S_RN_SEL: ring_ra = rpos_r;
      S_RN_H0: ring_ra = wadd(rpos_r, 18'd1);
      S_WR_H0: begin
        ring_we = 1'b1;
        ring_wd = tot_w[7:0];
      end
      S_WR_H1: begin
        ring_we = 1'b1;
        ring_wd = tot_w[15:8];
      end
      S_CP_WR: begin
        ring_we = 1'b1;
        ring_wd = stg_rd;
      end
      S_DOT: ring_we = 1'b1;
      default: ring_ra = oldest_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wpos_r <= '0;
      oldest_r <= '0;
      occ_r <= '0;
      lines_r <= '0;
      evict_r <= '0;
      staged_r <= '0;
      kept_r <= '0;
      rpos_r <= '0;
      rlines_r <= '0;
      rline_r <= '0;
      ropen_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && out_free) begin
        o_vld_r <= 1'b1;
      end else if (o_vld_r && !out_stall) begin
        o_vld_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_vld) begin
            res_vld_r <= 1'b0;
            res_last_r <= 1'b0;
            res_byte_r <= 8'd0;
            cp_r <= '0;
            dot_r <= 2'd0;
            case (q_item.cmd)
              CMD_PUSH: begin
                ropen_r <= 1'b0;
                if (!q_item.line_end) begin
                  res_st_r <= ST_STAGED;
                  kept_r <= kept_new;
                  if (staged_r <= SC_W'(LINE_MAX)) begin
                    staged_r <= sp1;
                  end
                end else begin
                  staged_r <= '0;
                  kept_r <= '0;
                  len_r <= len_new;
                  cut_r <= cut_new;
                  need_r <= need_new;
                  if (kept_new == '0) begin
                    res_st_r <= ST_EMPTY;
                  end else if (too_big) begin
                    res_st_r <= ST_TOO_BIG;
                  end else begin
                    res_st_r <= ST_OK;
                  end
                end
              end
              CMD_OPEN: begin
                res_st_r <= ST_OK;
                p_r <= oldest_r;
                wi_r <= '0;
                rem_r <= REM_W'(occ_r) + REM_W'(lines_r);
                max_r <= q_item.rd_budget;
                ropen_r <= (lines_r != '0 && !walk_need);
                if (lines_r != '0 && !walk_need) begin
                  rpos_r <= oldest_r;
                  rlines_r <= lines_r;
                  rline_r <= '0;
                end
              end
              CMD_NEXT: begin
                res_st_r <= ropen_r ? ST_OK : ST_NO_READ;
              end
              default: begin
                res_st_r <= ST_OK;
                wpos_r <= '0;
                oldest_r <= '0;
                occ_r <= '0;
                lines_r <= '0;
                staged_r <= '0;
                kept_r <= '0;
                ropen_r <= 1'b0;
              end
            endcase
          end
        end
        S_EVC_H0, S_OPN_H0, S_RN_H0: lo_r <= ring_rd;
        S_EVC_H1: begin
          oldest_r <= wadd(oldest_r, 18'(hdr_w) + 18'(HDR));
          if (18'(hdr_w) + 18'(HDR) > 18'(occ_r)) begin
            occ_r <= '0;
          end else begin
            occ_r <= OCC_W'(18'(occ_r) - 18'(hdr_w) - 18'(HDR));
          end
          lines_r <= lines_r - LN_W'(1);
          evict_r <= evict_r + DC_W'(1);
        end
        S_WR_H0, S_WR_H1: wpos_r <= wadd(wpos_r, 18'd1);
        S_CP_WR: begin
          wpos_r <= wadd(wpos_r, 18'd1);
          cp_r <= cp_r + SC_W'(1);
        end
        S_DOT: begin
          wpos_r <= wadd(wpos_r, 18'd1);
          dot_r <= dot_r + 2'd1;
        end
        S_CMT: begin
          occ_r <= occ_r + OCC_W'(need_r);
          lines_r <= lines_r + LN_W'(1);
        end
        S_OPN_CHK: begin
          if (!opn_go && wi_r != lines_r) begin
            rpos_r <= p_r;
            rlines_r <= lines_r - wi_r;
            rline_r <= '0;
            ropen_r <= 1'b1;
          end
        end
        S_OPN_H1: begin
          rem_r <= REM_W'(32'(rem_r) - 32'(hdr_w) - 32'(HDR + 1));
          p_r <= wadd(p_r, 18'(hdr_w) + 18'(HDR));
          wi_r <= wi_r + LN_W'(1);
        end
        S_RN_H1: begin
          rline_r <= LL_W'(17'(hdr_w) + 17'd1);
          rpos_r <= wadd(rpos_r, 18'(HDR));
        end
        S_RN_SEL: begin
          if (rline_r <= LL_W'(1)) begin
            res_byte_r <= CH_NL;
            res_vld_r <= 1'b1;
            rlines_r <= rlines_r - LN_W'(1);
            rline_r <= rline_r - LL_W'(1);
            if (rlines_r == LN_W'(1) && rline_r == LL_W'(1)) begin
              res_last_r <= 1'b1;
              ropen_r <= 1'b0;
            end
          end
        end
        S_RN_B: begin
          res_byte_r <= ring_rd;
          res_vld_r <= 1'b1;
          rpos_r <= wadd(rpos_r, 18'd1);
          rline_r <= rline_r - LL_W'(1);
        end
        S_DONE: begin
          if (out_free) begin
            out_out_byte <= res_byte_r;
            out_out_valid <= res_vld_r;
            out_out_last <= res_last_r;
            out_status <= res_st_r;
            out_line_count <= LC_W'(lines_r);
            out_bytes_used <= BU_W'(occ_r);
            out_dropped_count <= evict_r;
          end
        end
        default: begin
        end
      endcase
    end
  end
endmodule

[hw/rtl/length_prefixed_log_ring_unit.sv]
// Top level of the length-prefixed log ring: front queue plus execution back end.
// A commit evicts the oldest lines until the new line fits, then writes the header, the kept
// bytes and, for a cut line, the dots; a read open walks past the skipped lines' headers.
// The back end state machine takes a new transaction only after it has finished the last one.
// Synchronous active-low reset empties the ring and queue; memories are not cleared.
module length_prefixed_log_ring_unit #(
  parameter int CAPACITY = lpl_pkg::CAPACITY_DEF,
  parameter int LINE_MAX = lpl_pkg::LINE_MAX_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_cmd,
  input  logic [7:0]                in_data_byte,
  input  logic                      in_line_end,
  input  logic [lpl_pkg::MAX_W-1:0] in_rd_budget,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_out_byte,
  output logic                      out_out_valid,
  output logic                      out_out_last,
  output logic [2:0]                out_status,
  output logic [lpl_pkg::LC_W-1:0]  out_line_count,
  output logic [lpl_pkg::BU_W-1:0]  out_bytes_used,
  output logic [lpl_pkg::DC_W-1:0]  out_dropped_count
);
  import lpl_pkg::*;

  item_t q_item;
  logic  q_vld, q_pop;

  lpl_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(in_cmd), .in_data_byte(in_data_byte), .in_line_end(in_line_end),
    .in_rd_budget(in_rd_budget), .q_item(q_item), .q_vld(q_vld), .q_pop(q_pop)
  );

  lpl_back #(.CAPACITY(CAPACITY), .LINE_MAX(LINE_MAX)) u_back (
    .clk(clk), .rst_n(rst_n), .q_item(q_item), .q_vld(q_vld), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_out_byte(out_out_byte),
    .out_out_valid(out_out_valid), .out_out_last(out_out_last), .out_status(out_status),
    .out_line_count(out_line_count), .out_bytes_used(out_bytes_used),
    .out_dropped_count(out_dropped_count)
  );

  a_last_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_last) |-> out_out_valid)
    else $error("Last flag without a read byte.");

  a_byte_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_valid) |-> (out_status == ST_OK))
    else $error("Read byte with non-ok status.");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_bytes_used) <= 32'(CAPACITY)))
    else $error("Occupied bytes exceed capacity.");

  a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_vld)
    else $error("Queue popped while empty.");
endmodule

[test/tb.sv]
// Self-checking testbench of the length-prefixed log ring unit: directed table, then random command traffic.
module tb;
  import lpl_pkg::*;

  localparam int RING_SZ = CAPACITY_DEF;
  localparam int LMAX = LINE_MAX_DEF;

  typedef struct {
    logic [7:0] byte_v;
    logic valid_v;
    logic last_v;
    logic [2:0] status_v;
    logic [LC_W-1:0] lines_v;
    logic [BU_W-1:0] used_v;
    logic [DC_W-1:0] dropped_v;
  } log_result_t;

  typedef struct {
    cmd_t cmd;
    logic [7:0] data;
    logic le;
    logic [MAX_W-1:0] maxb;
    bit typed;
    status_t st;
    int lines;
    int used;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_cmd = CMD_NEXT;
  logic [7:0] in_data_byte = 0;
  logic in_line_end = 0;
  logic [MAX_W-1:0] in_rd_budget = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [7:0] out_out_byte;
  logic out_out_valid;
  logic out_out_last;
  logic [2:0] out_status;
  logic [LC_W-1:0] out_line_count;
  logic [BU_W-1:0] out_bytes_used;
  logic [DC_W-1:0] out_dropped_count;

  length_prefixed_log_ring_unit u_dut (.*);

  always #2 clk = ~clk;

  // Predicted state of the ring.
  logic [7:0] ring_mem [RING_SZ];
  logic [7:0] stage_mem [LMAX];
  int unsigned wr_ptr, old_ptr, used_bytes, line_total, drop_total;
  int unsigned stage_cnt, keep_len, rd_ptr, rd_lines, rd_left;
  bit rd_open;

  log_result_t result_q[$];
  int errors = 0;
  int tx_idle_pct = 21;
  int rx_idle_pct = 78;
  int unsigned cycles = 0;

  function automatic int unsigned hdr_at(int unsigned p);
    return 32'(ring_mem[p % RING_SZ]) | (32'(ring_mem[(p + 1) % RING_SZ]) << 8);
  endfunction

  function automatic void put_ring(logic [7:0] b);
    ring_mem[wr_ptr] = b;
    wr_ptr = (wr_ptr + 1) % RING_SZ;
  endfunction

  function automatic status_t commit_line();
    int unsigned len, total, need, sz;
    bit cut;
    len = keep_len;
    cut = 0;
    if (len == 0) return ST_EMPTY;
    if (len > LMAX) begin
      len = LMAX - 3;
      cut = 1;
    end
    total = len + (cut ? 3 : 0);
    need = HDR + total;
    if (need > RING_SZ) return ST_TOO_BIG;
    while (used_bytes + need > RING_SZ && line_total != 0) begin
      sz = HDR + hdr_at(old_ptr);
      old_ptr = (old_ptr + sz) % RING_SZ;
      used_bytes = (sz > used_bytes) ? 0 : used_bytes - sz;
      line_total--;
      drop_total++;
    end
    put_ring(total[7:0]);
    put_ring(total[15:8]);
    for (int i = 0; i < len; i++) put_ring(stage_mem[i]);
    if (cut) repeat (3) put_ring(CH_DOT);
    used_bytes += need;
    line_total++;
    return ST_OK;
  endfunction

  function automatic void open_window(int unsigned maxb);
    int unsigned start, skip, p, remaining, len;
    start = old_ptr;
    skip = 0;
    rd_open = 0;
    if (line_total == 0) return;
    if (maxb != 0 && used_bytes + line_total > maxb) begin
      p = old_ptr;
      remaining = used_bytes + line_total;
      for (int i = 0; i < line_total; i++) begin
        len = hdr_at(p);
        if (remaining <= maxb) break;
        remaining -= HDR + len + 1;
        p = (p + HDR + len) % RING_SZ;
        start = p;
        skip = i + 1;
      end
    end
    if (skip >= line_total) return;
    rd_ptr = start;
    rd_lines = line_total - skip;
    rd_left = 0;
    rd_open = 1;
  endfunction

  function automatic log_result_t predict_log(cmd_t c, logic [7:0] b, logic le,
                                             logic [MAX_W-1:0] maxb);
    log_result_t r;
    r = '{8'h00, 1'b0, 1'b0, ST_OK, 0, 0, 0};
    case (c)
      CMD_PUSH: begin
        rd_open = 0;
        r.status_v = ST_STAGED;
        if (stage_cnt < LMAX) stage_mem[stage_cnt] = b;
        if (b != CH_NL && b != CH_CR) keep_len = stage_cnt + 1;
        if (keep_len > LMAX + 1) keep_len = LMAX + 1;
        if (stage_cnt <= LMAX) stage_cnt++;
        if (le) begin
          r.status_v = commit_line();
          stage_cnt = 0;
          keep_len = 0;
        end
      end
      CMD_OPEN: open_window(maxb);
      CMD_NEXT: begin
        if (!rd_open) begin
          r.status_v = ST_NO_READ;
        end else begin
          if (rd_left == 0) begin
            rd_left = hdr_at(rd_ptr) + 1;
            rd_ptr = (rd_ptr + HDR) % RING_SZ;
          end
          if (rd_left > 1) begin
            r.byte_v = ring_mem[rd_ptr];
            rd_ptr = (rd_ptr + 1) % RING_SZ;
          end else begin
            r.byte_v = CH_NL;
            rd_lines--;
          end
          rd_left--;
          r.valid_v = 1;
          if (rd_lines == 0 && rd_left == 0) begin
            r.last_v = 1;
            rd_open = 0;
          end
        end
      end
      default: begin
        wr_ptr = 0;
        old_ptr = 0;
        used_bytes = 0;
        line_total = 0;
        stage_cnt = 0;
        keep_len = 0;
        rd_open = 0;
      end
    endcase
    r.lines_v = LC_W'(line_total);
    r.used_v = BU_W'(used_bytes);
    r.dropped_v = drop_total;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d, expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Drives one transaction and records its predicted result once it is accepted.
  task automatic send_cmd(cmd_t c, logic [7:0] b, logic le, logic [MAX_W-1:0] maxb,
                          bit typed = 0, status_t st = ST_OK, int lines = 0, int used = 0);
    log_result_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_cmd <= c;
    in_data_byte <= b;
    in_line_end <= le;
    in_rd_budget <= maxb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = predict_log(c, b, le, maxb);
    if (typed) begin
      r.status_v = st;
      r.lines_v = LC_W'(lines);
      r.used_v = BU_W'(used);
    end
    result_q = {result_q, r};
  endtask

  task automatic push_line(int len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(255));
      if (i >= len - 2 && $urandom_range(99) < 15) b = $urandom_range(1) ? CH_NL : CH_CR;
      send_cmd(CMD_PUSH, b, i == len - 1, MAX_W'($urandom));
    end
  endtask

  always @(posedge clk) begin
    log_result_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected transaction", 1, 0);
        end else begin
          e = result_q.pop_front();
          if (out_out_byte !== e.byte_v) report_mismatch("out_byte", out_out_byte, e.byte_v);
          if (out_out_valid !== e.valid_v)
            report_mismatch("out_valid", out_out_valid, e.valid_v);
          if (out_out_last !== e.last_v) report_mismatch("out_last", out_out_last, e.last_v);
          if (out_status !== e.status_v) report_mismatch("status", out_status, e.status_v);
          if (out_line_count !== e.lines_v)
            report_mismatch("line_count", out_line_count, e.lines_v);
          if (out_bytes_used !== e.used_v)
            report_mismatch("bytes_used", out_bytes_used, e.used_v);
          if (out_dropped_count !== e.dropped_v)
            report_mismatch("dropped_count", out_dropped_count, e.dropped_v);
        end
      end
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  row_t dir_rows[] = '{
    '{CMD_NEXT, 8'h00, 1'b0, 17'd0, 1, ST_NO_READ, 0, 0},
    '{CMD_OPEN, 8'h00, 1'b0, 17'd0, 1, ST_OK, 0, 0},
    '{CMD_PUSH, 8'h41, 1'b1, 17'd0, 1, ST_OK, 1, 3},
    '{CMD_PUSH, CH_NL, 1'b1, 17'd0, 1, ST_EMPTY, 1, 3},
    '{CMD_PUSH, CH_CR, 1'b0, 17'd0, 1, ST_STAGED, 1, 3},
    '{CMD_PUSH, CH_NL, 1'b1, 17'd0, 1, ST_EMPTY, 1, 3},
    '{CMD_PUSH, 8'hFF, 1'b0, 17'h1FFFF, 1, ST_STAGED, 1, 3},
    '{CMD_PUSH, 8'h00, 1'b0, 17'd0, 1, ST_STAGED, 1, 3},
    '{CMD_PUSH, CH_CR, 1'b1, 17'd0, 1, ST_OK, 2, 7},
    '{CMD_OPEN, 8'h00, 1'b0, 17'd0, 1, ST_OK, 2, 7},
    '{CMD_NEXT, 8'h00, 1'b0, 17'd0, 0, ST_OK, 0, 0},
    '{CMD_NEXT, 8'h00, 1'b0, 17'd0, 0, ST_OK, 0, 0},
    '{CMD_NEXT, 8'h00, 1'b0, 17'd0, 0, ST_OK, 0, 0},
    '{CMD_PUSH, 8'h42, 1'b1, 17'd0, 1, ST_OK, 3, 10},
    '{CMD_NEXT, 8'h00, 1'b0, 17'd0, 1, ST_NO_READ, 3, 10},
    '{CMD_OPEN, 8'h00, 1'b0, 17'd1, 1, ST_OK, 3, 10},
    '{CMD_NEXT, 8'h00, 1'b0, 17'd0, 1, ST_NO_READ, 3, 10},
    '{CMD_OPEN, 8'h00, 1'b0, 17'd4, 0, ST_OK, 0, 0},
    '{CMD_NEXT, 8'h00, 1'b0, 17'd0, 0, ST_OK, 0, 0},
    '{CMD_NEXT, 8'h00, 1'b0, 17'd0, 0, ST_OK, 0, 0},
    '{CMD_OPEN, 8'h00, 1'b0, 17'h1FFFF, 1, ST_OK, 3, 10},
    '{CMD_NEXT, 8'h00, 1'b0, 17'd0, 0, ST_OK, 0, 0},
    '{CMD_CLEAR, 8'h00, 1'b0, 17'd0, 1, ST_OK, 0, 0},
    '{CMD_NEXT, 8'h00, 1'b0, 17'd0, 1, ST_NO_READ, 0, 0}
  };

  initial begin
    int items;
    int pick;
    int len;
    wr_ptr = 0; old_ptr = 0; used_bytes = 0; line_total = 0; drop_total = 0;
    stage_cnt = 0; keep_len = 0; rd_ptr = 0; rd_lines = 0; rd_left = 0; rd_open = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    foreach (dir_rows[i])
      send_cmd(dir_rows[i].cmd, dir_rows[i].data, dir_rows[i].le, dir_rows[i].maxb,
               dir_rows[i].typed, dir_rows[i].st, dir_rows[i].lines, dir_rows[i].used);
    items = 0;
    while (items < 1700) begin
      if (items > 1133) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (items > 566) begin
        tx_idle_pct = 78;
        rx_idle_pct = 21;
      end
      pick = $urandom_range(99);
      if (pick < 55) begin
        len = ($urandom_range(99) < 25) ? $urandom_range(240, 300) : $urandom_range(1, 40);
        push_line(len);
        items += len;
      end else if (pick < 80) begin
        pick = $urandom_range(3);
        send_cmd(CMD_OPEN, 8'($urandom), 1'($urandom),
                 pick == 0 ? 17'd0 : pick == 3 ? 17'($urandom) : 17'($urandom_range(1, 150)));
        items++;
        while (rd_open && $urandom_range(99) < 98) begin
          send_cmd(CMD_NEXT, 8'($urandom), 1'($urandom), MAX_W'($urandom));
          items++;
        end
      end else if (pick < 90) begin
        send_cmd(CMD_NEXT, 8'($urandom), 1'($urandom), MAX_W'($urandom));
        items++;
      end else if (pick < 92) begin
        send_cmd(CMD_CLEAR, 8'($urandom), 1'($urandom), MAX_W'($urandom));
        items++;
      end else begin
        send_cmd(cmd_t'($urandom_range(3)), 8'($urandom), 1'($urandom), MAX_W'($urandom));
        items++;
      end
    end
    in_valid <= 0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
